// ===== hw/rtl/srs_pkg.sv =====
// Shared types, widths and constants for the systematic resampler.
// Depends on nothing; every other file in hw/rtl imports this package.
package srs_pkg;

    localparam int PARTICLES   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int OFFSET_BITS = 10;
    localparam int SOURCE_BITS = 6;

    localparam int IDX_W  = $clog2(PARTICLES);
    localparam int CNT_W  = $clog2(PARTICLES + 1);
    localparam int SUM_W  = WEIGHT_BITS + 1;
    localparam int SQ_W   = 2 * WEIGHT_BITS + 1;
    localparam int PROD_W = SQ_W + CNT_W + 2;

    localparam int PT_A  = CNT_W + OFFSET_BITS;
    localparam int PT_B  = IDX_W + WEIGHT_BITS;
    localparam int PT_W  = ((PT_A > PT_B) ? PT_A : PT_B) + 1;
    localparam int CUM_W = CNT_W + SUM_W;
    localparam int CMP_W = (PT_W > CUM_W) ? PT_W : CUM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
    localparam logic [SQ_W-1:0]   SQ_MAX     = '1;
    localparam logic [PROD_W-1:0] SKIP_LIMIT = PROD_W'(5) << (2 * WEIGHT_BITS);

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [OFFSET_BITS-1:0] start_offset;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [SOURCE_BITS-1:0] source_index;
        logic                   resampled;
        logic                   final_res;
    } result_t;

    typedef enum logic {
        CMD_WRITE,
        CMD_RUN
    } cmd_kind_t;

    // One command from the front to the back: either a store write or a run.
    typedef struct packed {
        cmd_kind_t              kind;
        logic [IDX_W-1:0]       idx;
        logic [SUM_W-1:0]       value;
        logic [CNT_W-1:0]       count;
        logic [OFFSET_BITS-1:0] offset;
        logic                   skip;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

endpackage

// ===== hw/rtl/systematic_resampler_core.sv =====
// Top level of the systematic resampler: front end, command queue, back end.
// Depends on srs_pkg, srs_front, srs_queue and srs_back.
//
// Usage. Weights of one particle set arrive on the item channel (valid/ready),
// one normalized Q0.16 weight per word, the final one marked by last, which
// also carries the random start offset. Results leave on the result channel
// (valid/ready). A set whose effective particle count is above 0.8 n gives a
// single word with resampled low and final_res high. Otherwise n words come
// out, one source index per new particle, the last one with final_res high.
// Weights past the 64th of a set are ignored, but last still closes the set.
//
// Timing. The front end accepts a weight and squares it, then folds the square
// into the sum of squares and queues a store write; it takes no new weight
// until that write is queued. The closing weight is then followed by the skip
// decision and the run command. The back end walks the cumulative-sum store at
// one step per cycle unless a stalled receiver holds back an index, either
// moving to the next entry or giving an index. The queue lets the next set
// load while the walk drains a stalled receiver; when the queue fills,
// item_ready drops. After reset all sums are zero and both sides are empty;
// the store needs no clearing since a walk only reads entries written for its
// own set.
module systematic_resampler_core
    import srs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic head_valid;
    logic head_ready;
    cmd_t head;

    srs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    srs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head)
    );

    srs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_ready   (head_ready),
        .head         (head),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A skipped set always reports index zero and closes the run.
    a_skip_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.resampled) |-> (result.final_res && result.source_index == '0))
        else $error("skipped-set result word is malformed");

    // A run command always covers at least one and at most PARTICLES weights.
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_cmd.kind == CMD_RUN) |->
            (push_cmd.count != '0 && push_cmd.count <= CNT_W'(PARTICLES)))
        else $error("run command with an impossible particle count");

    // The back end only takes a command that the queue actually holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        head_ready |-> head_valid)
        else $error("back end consumed a command from an empty queue");

endmodule

// ===== hw/rtl/srs_front.sv =====
// Front end of the resampler: accepts weights, keeps the running sums and
// decides skip or walk at the end of a set. Depends on srs_pkg.
module srs_front
    import srs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  push_valid,
    input  logic  push_ready,
    output cmd_t  push_cmd
);

    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SQ_W-1:0]          sq_sum_reg, sq_sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [2*WEIGHT_BITS-1:0] prod_reg, prod_next;
    logic                     pend_reg, pend_next;
    logic                     pend_last_reg, pend_last_next;
    logic                     pend_load_reg, pend_load_next;
    logic [IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic [OFFSET_BITS-1:0]   pend_off_reg, pend_off_next;
    logic                     dec_reg, dec_next;

    logic                     accept;
    logic                     load;
    logic [SUM_W:0]           sum_wide;
    logic [SQ_W:0]            sq_wide;
    logic [PROD_W-1:0]        neff_prod;
    logic                     skip;
    logic                     pend_done;

    assign item_ready = !pend_reg && !dec_reg;
    assign accept     = item_valid && item_ready;
    assign load       = count_reg < CNT_W'(PARTICLES);
    assign sum_wide   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(item.weight);
    assign sq_wide    = (SQ_W+1)'(sq_sum_reg) + (SQ_W+1)'(prod_reg);

    // Neff above 0.8n is the same as sumsq * 4n below five in Q0.(2W).
    assign neff_prod = PROD_W'(sq_sum_reg) * PROD_W'({count_reg, 2'b00});
    assign skip      = (sq_sum_reg == '0) || (neff_prod < SKIP_LIMIT);

    assign pend_done  = pend_reg && (!pend_load_reg || push_ready);
    assign push_valid = (pend_reg && pend_load_reg) || dec_reg;

    always_comb
    begin
        push_cmd        = '0;
        push_cmd.kind   = dec_reg ? CMD_RUN : CMD_WRITE;
        push_cmd.idx    = pend_idx_reg;
        push_cmd.value  = sum_reg;
        push_cmd.count  = count_reg;
        push_cmd.offset = pend_off_reg;
        push_cmd.skip   = skip;
    end

    always_comb
    begin
        sum_next       = sum_reg;
        sq_sum_next    = sq_sum_reg;
        count_next     = count_reg;
        prod_next      = prod_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_load_next = pend_load_reg;
        pend_idx_next  = pend_idx_reg;
        pend_off_next  = pend_off_reg;
        dec_next       = dec_reg;

        if (accept)
        begin
            pend_next      = 1'b1;
            pend_last_next = item.last;
            pend_load_next = load;
            pend_off_next  = item.start_offset;
            pend_idx_next  = count_reg[IDX_W-1:0];
            prod_next      = (2*WEIGHT_BITS)'(item.weight) * (2*WEIGHT_BITS)'(item.weight);
            if (load)
            begin
                sum_next   = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (pend_done)
        begin
            pend_next = 1'b0;
            if (pend_load_reg)
            begin
                sq_sum_next = (sq_wide > (SQ_W+1)'(SQ_MAX)) ? SQ_MAX : sq_wide[SQ_W-1:0];
            end
            if (pend_last_reg)
            begin
                dec_next = 1'b1;
            end
        end

        if (dec_reg && push_ready)
        begin
            dec_next    = 1'b0;
            sum_next    = '0;
            sq_sum_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            sq_sum_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            dec_reg    <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            sq_sum_reg <= sq_sum_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            dec_reg    <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        pend_last_reg <= pend_last_next;
        pend_load_reg <= pend_load_next;
        pend_idx_reg  <= pend_idx_next;
        pend_off_reg  <= pend_off_next;
    end

endmodule

// ===== hw/rtl/srs_queue.sv =====
// Short command queue between the resampler front and back.
// Depends on srs_pkg for the command type and depth.
module srs_queue
    import srs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic head_valid,
    input  logic head_ready,
    output cmd_t head
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/srs_back.sv =====
// Back end of the resampler: owns the cumulative-sum store and walks it.
// Depends on srs_pkg.
module srs_back
    import srs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    output logic    head_ready,
    input  cmd_t    head,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic [SUM_W-1:0] store_mem [PARTICLES];
    logic [SUM_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CMP_W-1:0] point_reg, point_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             out_free;
    logic             mem_we;
    logic             emit;
    result_t          emit_data;
    logic             advance;
    logic             last_point;
    logic [CMP_W-1:0] cum_scaled;

    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign cum_scaled = CMP_W'(n_reg) * CMP_W'(rd_data_reg);
    assign advance    = (CNT_W'(i_reg) + CNT_W'(1) < n_reg) && (point_reg > cum_scaled);
    assign last_point = (j_reg + CNT_W'(1)) == n_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head.kind == CMD_RUN && !head.skip)
                begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (!advance && out_free && last_point)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_ready = 1'b0;
        mem_we     = 1'b0;
        emit       = 1'b0;
        emit_data  = '0;
        rd_addr    = '0;
        n_next     = n_reg;
        point_next = point_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head.kind)
                        CMD_WRITE:
                        begin
                            head_ready = 1'b1;
                            mem_we     = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            if (head.skip)
                            begin
                                head_ready          = out_free;
                                emit                = out_free;
                                emit_data.final_res = 1'b1;
                            end
                            else
                            begin
                                head_ready = 1'b1;
                                n_next     = head.count;
                                point_next = CMP_W'(head.count) * CMP_W'(head.offset);
                                i_next     = '0;
                                j_next     = '0;
                            end
                        end
                        default:
                        begin
                            head_ready = 1'b0;
                        end
                    endcase
                end
            end
            BK_WALK:
            begin
                rd_addr = i_reg;
                if (advance)
                begin
                    i_next  = i_reg + IDX_W'(1);
                    rd_addr = i_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    emit                   = 1'b1;
                    emit_data.source_index = SOURCE_BITS'(i_reg);
                    emit_data.resampled    = 1'b1;
                    emit_data.final_res    = last_point;
                    j_next                 = j_reg + CNT_W'(1);
                    point_next             = point_reg + (CMP_W'(1) << WEIGHT_BITS);
                end
            end
            default:
            begin
                head_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        point_reg <= point_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[head.idx] <= head.value;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

endmodule
